/* design/assert_macros.svh */
// assertion macros included by the top level of the rational unit
// no dependencies; expects i_clk and i_rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define AST_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/rau_pkg.sv */
// shared codes and controller/datapath signal groups of the rational unit
// no dependencies
package rau_pkg;

    // operation codes
    localparam logic [3:0] K_NORM = 4'd0;
    localparam logic [3:0] K_ADD  = 4'd1;
    localparam logic [3:0] K_SUB  = 4'd2;
    localparam logic [3:0] K_MUL  = 4'd3;
    localparam logic [3:0] K_DIV  = 4'd4;
    localparam logic [3:0] K_ABS  = 4'd5;
    localparam logic [3:0] K_OPP  = 4'd6;
    localparam logic [3:0] K_NEGV = 4'd7;
    localparam logic [3:0] K_REC  = 4'd8;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDIV = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // multiplier pass select
    localparam logic [1:0] MS_T1  = 2'd0;
    localparam logic [1:0] MS_T2  = 2'd1;
    localparam logic [1:0] MS_DEN = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       combine;
        logic       gcd_init;
        logic       gcd_two;
        logic       gcd_step;
        logic       g_shift;
        logic       div_load;
        logic       div_den;
        logic       div_step;
        logic       save_den;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic err;
        logic num_zero;
        logic both_even;
        logic x_zero;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage

/* design/rau_in_if.sv */
// input channel of the rational unit: operation and two fractions
// no dependencies
interface rau_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;

    modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

/* design/rau_out_if.sv */
// output channel of the rational unit: reduced fraction and status
// no dependencies
interface rau_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic [1:0]  status;

    modport source (output valid, res_num, res_den, status, input ready);
    modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

/* design/rau_datapath.sv */
// datapath of the rational unit: multiplier, combine, binary gcd, divider, output
// depends on rau_pkg
module rau_datapath import rau_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [3:0]  i_kind,
    input  logic [31:0] i_a_num,
    input  logic [31:0] i_a_den,
    input  logic [31:0] i_b_num,
    input  logic [31:0] i_b_den,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_res_num,
    output logic [30:0] o_res_den,
    output logic [1:0]  o_status
);

    localparam int PW = 2 * WIDTH;
    localparam int L  = 2 * WIDTH + 1;
    localparam int KW = $clog2(L);

    function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] v);
        return v[WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    logic [3:0]       r_kind;
    logic [WIDTH-1:0] r_an, r_ad, r_bn, r_bd;
    logic             r_asg, r_bsg;
    logic [1:0]       r_st;
    logic [PW-1:0]    r_t1, r_t2;
    logic [L-1:0]     r_num, r_den;
    logic             r_neg;
    logic [L-1:0]     r_x, r_y, r_g;
    logic [KW-1:0]    r_k;
    logic [L-1:0]     r_rem, r_quo;
    logic [KW-1:0]    r_dcnt;
    logic             r_ovalid;
    logic [31:0]      r_res_num;
    logic [30:0]      r_res_den;
    logic [1:0]       r_status;

    // capture
    logic [WIDTH-1:0] c_an, c_ad, c_bn, c_bd;
    logic             c_asg, c_bsg, c_err;

    always_comb begin
        c_an  = mag(i_a_num[WIDTH-1:0]);
        c_ad  = mag(i_a_den[WIDTH-1:0]);
        c_bn  = mag(i_b_num[WIDTH-1:0]);
        c_bd  = mag(i_b_den[WIDTH-1:0]);
        c_asg = (i_a_num[WIDTH-1] ^ i_a_den[WIDTH-1]) && (c_an != '0);
        c_bsg = (i_b_num[WIDTH-1] ^ i_b_den[WIDTH-1]) && (c_bn != '0);
        c_err = (i_kind > K_REC) || (c_ad == '0)
              || ((i_kind inside {K_ADD, K_SUB, K_MUL, K_DIV}) && (c_bd == '0))
              || ((i_kind == K_DIV) && (c_bn == '0))
              || ((i_kind == K_REC) && (c_an == '0));
    end

    // multiplier operand select
    logic [WIDTH-1:0] m_op1, m_op2;
    logic [PW-1:0]    m_prod;
    localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

    always_comb begin
        m_op1 = r_an;
        m_op2 = ONE;
        case (i_cmd.mul_sel)
            MS_T1: begin
                case (r_kind)
                    K_ADD, K_SUB, K_DIV: begin m_op1 = r_an; m_op2 = r_bd; end
                    K_MUL:               begin m_op1 = r_an; m_op2 = r_bn; end
                    K_REC:               begin m_op1 = r_ad; m_op2 = ONE;  end
                    default:             begin m_op1 = r_an; m_op2 = ONE;  end
                endcase
            end
            MS_T2: begin
                m_op1 = r_bn;
                m_op2 = r_ad;
            end
            MS_DEN: begin
                case (r_kind)
                    K_ADD, K_SUB, K_MUL: begin m_op1 = r_ad; m_op2 = r_bd; end
                    K_DIV:               begin m_op1 = r_ad; m_op2 = r_bn; end
                    K_REC:               begin m_op1 = r_an; m_op2 = ONE;  end
                    default:             begin m_op1 = r_ad; m_op2 = ONE;  end
                endcase
            end
            default: begin
                m_op1 = r_an;
                m_op2 = ONE;
            end
        endcase
        m_prod = PW'(m_op1) * PW'(m_op2);
    end

    // combine
    logic [L-1:0] t1e, t2e, n_cnum;
    logic         n_cneg, s1, s2;

    always_comb begin
        t1e    = L'(r_t1);
        t2e    = L'(r_t2);
        s1     = r_asg;
        s2     = (r_kind == K_SUB) ? !r_bsg : r_bsg;
        n_cnum = t1e;
        n_cneg = 1'b0;
        case (r_kind)
            K_ADD, K_SUB: begin
                if (s1 == s2) begin
                    n_cnum = t1e + t2e;
                    n_cneg = s1;
                end else if (r_t1 >= r_t2) begin
                    n_cnum = t1e - t2e;
                    n_cneg = s1;
                end else begin
                    n_cnum = t2e - t1e;
                    n_cneg = s2;
                end
            end
            K_NORM, K_REC: n_cneg = r_asg;
            K_MUL, K_DIV:  n_cneg = r_asg ^ r_bsg;
            K_ABS:         n_cneg = 1'b0;
            K_OPP:         n_cneg = !r_asg;
            K_NEGV:        n_cneg = 1'b1;
            default:       n_cneg = 1'b0;
        endcase
    end

    // binary gcd step
    logic [L:0]   g_dxy;
    logic [L-1:0] g_dyx;

    always_comb begin
        g_dxy = {1'b0, r_x} - {1'b0, r_y};
        g_dyx = r_y - r_x;
    end

    // restoring divider step
    logic [L:0] d_sh, d_tr;

    always_comb begin
        d_sh = {r_rem, r_quo[L-1]};
        d_tr = d_sh - {1'b0, r_g};
    end

    // output formatting and range check
    localparam logic [L-1:0] LIM = L'(1) << (WIDTH - 1);
    logic             f_ovf;
    logic [WIDTH-1:0] f_sv;

    always_comb begin
        f_ovf = (r_den > (LIM - 1'b1)) || (r_num > (r_neg ? LIM : (LIM - 1'b1)));
        f_sv  = r_neg ? (~r_num[WIDTH-1:0] + 1'b1) : r_num[WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_an   <= c_an;
            r_ad   <= c_ad;
            r_bn   <= c_bn;
            r_bd   <= c_bd;
            r_asg  <= c_asg;
            r_bsg  <= c_bsg;
            r_st   <= c_err ? ST_ZDIV : ST_OK;
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                MS_T1:   r_t1  <= m_prod;
                MS_T2:   r_t2  <= m_prod;
                MS_DEN:  r_den <= L'(m_prod);
                default: r_t1  <= m_prod;
            endcase
        end
        if (i_cmd.combine) begin
            r_num <= n_cnum;
            r_neg <= n_cneg;
        end
        if (i_cmd.gcd_init) begin
            r_x <= r_num;
            r_y <= r_den;
            r_k <= '0;
        end
        if (i_cmd.gcd_two) begin
            r_x <= r_x >> 1;
            r_y <= r_y >> 1;
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.gcd_step) begin
            if (!r_x[0]) begin
                r_x <= r_x >> 1;
            end else if (!r_y[0]) begin
                r_y <= r_y >> 1;
            end else if (!g_dxy[L]) begin
                r_x <= g_dxy[L-1:0] >> 1;
            end else begin
                r_y <= g_dyx >> 1;
            end
        end
        if (i_cmd.g_shift) begin
            r_g <= r_y << r_k;
        end
        if (i_cmd.div_load) begin
            r_rem  <= '0;
            r_dcnt <= KW'(L - 1);
            if (i_cmd.div_den) begin
                r_quo <= r_den;
                r_num <= r_quo;
            end else begin
                r_quo <= r_num;
            end
        end
        if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt - 1'b1;
            if (!d_tr[L]) begin
                r_rem <= d_tr[L-1:0];
                r_quo <= {r_quo[L-2:0], 1'b1};
            end else begin
                r_rem <= d_sh[L-1:0];
                r_quo <= {r_quo[L-2:0], 1'b0};
            end
        end
        if (i_cmd.save_den) begin
            r_den <= r_quo;
        end
        if (i_cmd.finish) begin
            if (r_st != ST_OK) begin
                r_res_num <= '0;
                r_res_den <= 31'd1;
                r_status  <= r_st;
            end else if (r_num == '0) begin
                r_res_num <= '0;
                r_res_den <= 31'd1;
                r_status  <= ST_OK;
            end else if (f_ovf) begin
                r_res_num <= '0;
                r_res_den <= 31'd1;
                r_status  <= ST_OVF;
            end else begin
                r_res_num <= 32'(signed'(f_sv));
                r_res_den <= 31'(r_den[WIDTH-2:0]);
                r_status  <= ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_stat.err       = (r_st != ST_OK);
    assign o_stat.num_zero  = (r_num == '0);
    assign o_stat.both_even = !r_x[0] && !r_y[0];
    assign o_stat.x_zero    = (r_x == '0);
    assign o_stat.div_last  = (r_dcnt == '0);
    assign o_stat.out_free  = !r_ovalid || i_ready;

    assign o_valid   = r_ovalid;
    assign o_res_num = r_res_num;
    assign o_res_den = r_res_den;
    assign o_status  = r_status;

endmodule

/* design/rau_ctrl.sv */
// sequencer of the rational unit: steps the datapath through one item
// depends on rau_pkg
module rau_ctrl import rau_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL0   = 4'd1;
    localparam logic [3:0] S_MUL1   = 4'd2;
    localparam logic [3:0] S_MUL2   = 4'd3;
    localparam logic [3:0] S_COMB   = 4'd4;
    localparam logic [3:0] S_DECIDE = 4'd5;
    localparam logic [3:0] S_GTWO   = 4'd6;
    localparam logic [3:0] S_GLOOP  = 4'd7;
    localparam logic [3:0] S_DNLD   = 4'd8;
    localparam logic [3:0] S_DN     = 4'd9;
    localparam logic [3:0] S_DDLD   = 4'd10;
    localparam logic [3:0] S_DD     = 4'd11;
    localparam logic [3:0] S_SAVE   = 4'd12;
    localparam logic [3:0] S_FIN    = 4'd13;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) n_state = S_MUL0;
            end
            S_MUL0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_T1;
                n_state       = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_T2;
                n_state       = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_DEN;
                n_state       = S_COMB;
            end
            S_COMB: begin
                o_cmd.combine = 1'b1;
                n_state       = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_stat.err || i_stat.num_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.gcd_init = 1'b1;
                    n_state        = S_GTWO;
                end
            end
            S_GTWO: begin
                if (i_stat.both_even) o_cmd.gcd_two = 1'b1;
                else                  n_state       = S_GLOOP;
            end
            S_GLOOP: begin
                if (i_stat.x_zero) begin
                    o_cmd.g_shift = 1'b1;
                    n_state       = S_DNLD;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DNLD: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_DN;
            end
            S_DN: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = S_DDLD;
            end
            S_DDLD: begin
                o_cmd.div_load = 1'b1;
                o_cmd.div_den  = 1'b1;
                n_state        = S_DD;
            end
            S_DD: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = S_SAVE;
            end
            S_SAVE: begin
                o_cmd.save_den = 1'b1;
                n_state        = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* design/rational_arith_unit.sv */
// top level of the rational unit: sequencer plus datapath
// depends on rau_pkg, rau_in_if, rau_out_if, rau_ctrl, rau_datapath, assert_macros.svh
//
// fraction alu: each item carries an operation (normalize, add, subtract,
// multiply, divide, abs, opposite, force-negative, reciprocal) and two WIDTH-bit
// two's complement fractions; the result is reduced by the gcd, sign on the
// numerator, positive denominator, zero as 0/1, with status 1 for a zero
// denominator, zero divisor or unknown operation and status 2 when the reduced
// result does not fit, both returning 0/1. one item is in work at a time; the
// result sits in an output register, so the next item is taken while it waits.
// an item runs through the multiplier passes and the combine; when the result
// is an error or zero it then finishes, otherwise it runs the binary gcd on
// the (2*WIDTH+1)-bit intermediate numerator and denominator and then the two
// bit-serial divisions by the gcd
`include "assert_macros.svh"
module rational_arith_unit import rau_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rau_in_if.sink    i_in,
    rau_out_if.source o_out
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer: one state per multiplier pass, gcd and divider loops
    rau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath: operand magnitudes, shared multiplier, gcd and divider
    rau_datapath #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_kind    (i_in.kind),
        .i_a_num   (i_in.a_num),
        .i_a_den   (i_in.a_den),
        .i_b_num   (i_in.b_num),
        .i_b_den   (i_in.b_den),
        .o_valid   (o_out.valid),
        .i_ready   (o_out.ready),
        .o_res_num (o_out.res_num),
        .o_res_den (o_out.res_den),
        .o_status  (o_out.status)
    );

    // a result never carries a zero denominator
    `AST_IMP(a_den_nonzero, o_out.valid, o_out.res_den != 31'd0)
    // any failing status returns 0/1
    `AST_IMP(a_err_zero, o_out.valid && (o_out.status != ST_OK),
             (o_out.res_num == 32'd0) && (o_out.res_den == 31'd1))
    // one item in work at a time
    `AST_NXT(a_one_item, i_in.valid && i_in.ready, !i_in.ready)
    // a finish never overwrites a result still waiting
    `AST_IMP(a_no_overrun, cmd.finish, stat.out_free)

endmodule

/* test/rau_checker.sv */
`timescale 1ns / 1ps
// checker for the rational unit: watches both channels, predicts each reduced
// fraction and compares it; depends on rau_pkg, rau_in_if, rau_out_if
module rau_checker import rau_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rau_in_if           i_in,
    rau_out_if          i_out,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results
);

    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        logic [1:0]  status;
    } t_fraction_res;

    t_fraction_res expected_fracs[$];
    int            fail_count = 0;
    int            result_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_fracs.size();
    assign o_results    = result_count;

    // magnitude of a WIDTH-bit two's complement field, sign returned separately
    function automatic logic [63:0] field_magnitude(input logic [31:0] raw,
                                                    output logic neg);
        logic [63:0] v;
        v = 64'(raw) & ((64'd1 << WIDTH) - 1);
        neg = v[WIDTH-1];
        return neg ? ((64'd1 << WIDTH) - v) : v;
    endfunction

    function automatic logic [63:0] euclid_gcd(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] r;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    // reduce and range-check one signed-magnitude fraction
    function automatic t_fraction_res reduce_fraction(input logic neg, input logic [63:0] n,
                                                      input logic [63:0] d,
                                                      input logic [1:0] st);
        t_fraction_res r;
        logic [63:0] lim, g;
        lim = 64'd1 << (WIDTH - 1);
        if (st == ST_OK && d == 0) st = ST_ZDIV;
        if (st == ST_OK) begin
            if (n == 0) begin
                neg = 1'b0;
                d = 1;
            end else begin
                g = euclid_gcd(n, d);
                n = n / g;
                d = d / g;
            end
            if (d > lim - 1 || n > (neg ? lim : lim - 1)) st = ST_OVF;
        end
        if (st != ST_OK) begin
            neg = 1'b0;
            n = 0;
            d = 1;
        end
        r.num = neg ? 32'(-n) : 32'(n);
        r.den = 31'(d);
        r.status = st;
        return r;
    endfunction

    function automatic t_fraction_res predict_fraction(input logic [3:0] kind,
            input logic [31:0] an, input logic [31:0] ad,
            input logic [31:0] bn, input logic [31:0] bd);
        logic        ann, adn, bnn, bdn, aneg, bneg, s1, s2;
        logic [63:0] amag, adm, bmag, bdm, t1, t2;
        amag = field_magnitude(an, ann);
        adm  = field_magnitude(ad, adn);
        bmag = field_magnitude(bn, bnn);
        bdm  = field_magnitude(bd, bdn);
        aneg = (ann != adn) && amag != 0;
        bneg = (bnn != bdn) && bmag != 0;
        if (kind > K_REC || adm == 0) return reduce_fraction(0, 0, 1, ST_ZDIV);
        if (kind >= K_ADD && kind <= K_DIV && bdm == 0)
            return reduce_fraction(0, 0, 1, ST_ZDIV);
        case (kind)
            K_NORM: return reduce_fraction(aneg, amag, adm, ST_OK);
            K_ADD, K_SUB: begin
                t1 = amag * bdm;
                t2 = bmag * adm;
                s1 = aneg;
                s2 = (kind == K_SUB) ? !bneg : bneg;
                if (s1 == s2) return reduce_fraction(s1, t1 + t2, adm * bdm, ST_OK);
                if (t1 >= t2) return reduce_fraction(s1, t1 - t2, adm * bdm, ST_OK);
                return reduce_fraction(s2, t2 - t1, adm * bdm, ST_OK);
            end
            K_MUL: return reduce_fraction(aneg != bneg, amag * bmag, adm * bdm, ST_OK);
            K_DIV: begin
                if (bmag == 0) return reduce_fraction(0, 0, 1, ST_ZDIV);
                return reduce_fraction(aneg != bneg, amag * bdm, adm * bmag, ST_OK);
            end
            K_ABS:  return reduce_fraction(1'b0, amag, adm, ST_OK);
            K_OPP:  return reduce_fraction(!aneg, amag, adm, ST_OK);
            K_NEGV: return reduce_fraction(1'b1, amag, adm, ST_OK);
            default: begin
                if (amag == 0) return reduce_fraction(0, 0, 1, ST_ZDIV);
                return reduce_fraction(aneg, adm, amag, ST_OK);
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_fraction_res want;
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready)
                expected_fracs.push_back(predict_fraction(i_in.kind, i_in.a_num, i_in.a_den,
                                                          i_in.b_num, i_in.b_den));
            if (i_out.valid && i_out.ready) begin
                result_count++;
                if (expected_fracs.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h/%h st %0d",
                                 i_out.res_num, i_out.res_den, i_out.status);
                end else begin
                    want = expected_fracs.pop_front();
                    if (want.num !== i_out.res_num || want.den !== i_out.res_den
                            || want.status !== i_out.status) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result %0d: expected %h/%h st %0d, got %h/%h st %0d",
                                     result_count, want.num, want.den, want.status,
                                     i_out.res_num, i_out.res_den, i_out.status);
                    end
                end
            end
        end
    end

endmodule

/* test/tb_rational_arith_unit.sv */
`timescale 1ns / 1ps
// testbench top for the rational unit: directed and random fraction items
// depends on rau_pkg, rau_in_if, rau_out_if, rational_arith_unit, rau_checker
module tb_rational_arith_unit import rau_pkg::*;;

    localparam int WIDTH      = 32;
    localparam int N_RANDOM   = 1430;
    localparam int CYCLE_CAP  = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count, pending, results;
    int   cycles = 0;
    int   send_idle_pct = 7, recv_idle_pct = 77;
    bit   recv_hold = 1'b0;
    int   items_sent = 0;

    rau_in_if  in_ch();
    rau_out_if out_ch();

    rational_arith_unit #(.WIDTH(WIDTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    rau_checker #(.WIDTH(WIDTH)) checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch),
        .o_fail_count(fail_count), .o_pending(pending), .o_results(results)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // random operand biased toward edge values and small values
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(4)) - 2);
            3, 4: return $urandom;
            5: return 32'($urandom_range(65535)) ^ ($urandom_range(1) ? 32'hffff_ffff : 32'h0);
            default: return 32'(int'($urandom_range(200)) - 100);
        endcase
    endfunction

    // offer one item and hold it until accepted
    task automatic send_fraction(input logic [3:0] kind, input logic [31:0] an,
                                 input logic [31:0] ad, input logic [31:0] bn,
                                 input logic [31:0] bd);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind  <= kind;
        in_ch.a_num <= an;
        in_ch.a_den <= ad;
        in_ch.b_num <= bn;
        in_ch.b_den <= bd;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] an, ad;
        logic [3:0]  kind;
        in_ch.valid = 1'b0;
        in_ch.kind  = K_NORM;
        in_ch.a_num = '0;
        in_ch.a_den = 32'd1;
        in_ch.b_num = '0;
        in_ch.b_den = 32'd1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every operation on ordinary values
        for (int k = 0; k <= 8; k++)
            send_fraction(4'(k), -32'sd6, 32'd4, 32'd3, -32'sd9);
        // zero denominators on either side, zero divisors, unknown kinds
        send_fraction(K_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
        send_fraction(K_MUL, 32'd1, 32'd2, 32'd1, 32'd0);
        send_fraction(K_DIV, 32'd1, 32'd2, 32'd0, 32'd5);
        send_fraction(K_REC, 32'd0, 32'd7, 32'd0, 32'd0);
        send_fraction(4'd9, 32'd1, 32'd1, 32'd1, 32'd1);
        send_fraction(4'd15, 32'd1, 32'd1, 32'd1, 32'd1);
        // unused b ignored even with zero denominator
        send_fraction(K_OPP, 32'd5, 32'd10, 32'd3, 32'd0);
        // overflow and range edges: most negative over minus one, its magnitude, and other extremes
        send_fraction(K_NORM, 32'h8000_0000, 32'hffff_ffff, 32'd0, 32'd1);
        send_fraction(K_ABS, 32'h8000_0000, 32'd1, 32'd0, 32'd1);
        send_fraction(K_NEGV, 32'h8000_0000, 32'd1, 32'd0, 32'd1);
        send_fraction(K_REC, 32'd1, 32'h8000_0000, 32'd0, 32'd1);
        send_fraction(K_MUL, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
        send_fraction(K_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        send_fraction(K_SUB, 32'h8000_0000, 32'd3, 32'h7fff_ffff, 32'd3);
        send_fraction(K_DIV, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'h8000_0000);
        send_fraction(K_SUB, 32'd0, 32'hffff_ffff, 32'd0, 32'd5);
        drain_results();

        // long receiver hold-off while items keep coming
        recv_hold = 1'b1;
        fork
            begin
                repeat (2000) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            for (int i = 0; i < 12; i++)
                send_fraction(4'($urandom_range(8)), pick_operand(), pick_operand(),
                              pick_operand(), pick_operand());
        join
        drain_results();

        // random traffic over three idle phases
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) begin
                send_idle_pct = 77;
                recv_idle_pct = 7;
            end else if (i == 2 * N_RANDOM / 3) begin
                drain_results();
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            kind = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9))
                                            : 4'($urandom_range(8));
            an = pick_operand();
            ad = pick_operand();
            if (ad == 0 && $urandom_range(3) != 0) ad = 32'd1;
            send_fraction(kind, an, ad, pick_operand(), pick_operand());
        end
        drain_results();
        repeat (300) @(posedge i_clk);

        $display("covered %0d items of all nine operations plus unknown kinds,", items_sent);
        $display("with zero divisors, overflow extremes and a long output stall");
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
